[rtl/spfu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spfu_pkg;

  // 1.0 in Q2.30
  localparam logic [31:0] QOne = 32'd1073741824;

  // one result bit of the square root per step
  localparam int unsigned SqrtSteps = 16;

  // accepted pair waiting for the back end; a = 2^30 - S, in 1 .. 2^30
  typedef struct packed {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic [30:0]        a;
  } spfu_item_t;

  // one stage of the square root pipeline
  typedef struct packed {
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] z;
    logic [30:0]        rem;
    logic [30:0]        res;
  } spfu_stage_t;

  function automatic logic signed [15:0] sat_q15(input logic signed [18:0] val);
    logic signed [15:0] r;
    if (val > 19'sd32767) begin
      r = 16'sd32767;
    end else if (val < -19'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = $signed(val[15:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/spfu_intf.sv]
`timescale 1ns / 1ps
`default_nettype none

interface spfu_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] u_in;
  logic signed [15:0] v_in;

  modport source (output valid, output u_in, output v_in, input ready);
  modport sink (input valid, input u_in, input v_in, output ready);
endinterface

interface spfu_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_out;
  logic signed [15:0] y_out;
  logic signed [15:0] z_out;

  modport source (output valid, output x_out, output y_out, output z_out, input ready);
  modport sink (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

`default_nettype wire

[rtl/sphere_point_from_uniform_pair.sv]
// Sphere point picking from a pair of uniform Q1.15 values.
// Input channel in_i carries u_in and v_in; each beat is one candidate pair.
// Output channel out_o carries x_out, y_out, z_out (Q1.15) of a unit-sphere point.
// Pairs with u*u + v*v >= 1 are dropped and give no output beat; the
// receiver counts points, the source keeps feeding pairs.
// Throughput: one pair per cycle while out_o is not stalled. A kept pair
// passes 2 front stages, the queue, 17 root stages, multiply and the output
// register on its way to out_o. Each root stage after the first adds one bit.
// Front (squares, reject test) and back (root, scaling) are split by a
// QDepth-entry queue; the front stalls in_i only when the queue is full.
// A stall on out_o freezes the back pipeline; pairs keep entering until the
// queue fills, then in_i.ready drops. Output holds stable while stalled.
// Reset (rst_ni low, asynchronous) empties all stages and the queue; no
// other state is kept between pairs.
`timescale 1ns / 1ps
`default_nettype none

module sphere_point_from_uniform_pair
  import spfu_pkg::*;
#(
  parameter int unsigned QDepth = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spfu_in_if.sink    in_i,
  spfu_out_if.source out_o
);

  spfu_item_t push_item, head;
  logic       push_valid, push_ready;
  logic       head_valid, pop;

  spfu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  spfu_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  spfu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

[rtl/spfu_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module spfu_front
  import spfu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spfu_in_if.sink   in_i,
  output spfu_item_t push_item_o,
  output logic      push_valid_o,
  input  wire logic push_ready_i
);

  logic               s1_valid_q;
  logic signed [15:0] s1_u_q, s1_v_q;
  logic               s2_valid_q;
  logic signed [15:0] s2_u_q, s2_v_q;
  logic [30:0]        s2_uu_q, s2_vv_q;

  logic signed [31:0] uu_full, vv_full;
  logic [31:0]        s_sum;
  logic [31:0]        a_full;
  logic               keep;
  logic               adv;

  assign uu_full = s1_u_q * s1_u_q;
  assign vv_full = s1_v_q * s1_v_q;

  assign s_sum  = {1'b0, s2_uu_q} + {1'b0, s2_vv_q};
  assign keep   = s_sum < QOne;
  assign a_full = QOne - s_sum;

  // rejected pairs simply drop out of stage 2
  assign push_valid_o = s2_valid_q && keep;
  assign push_item_o  = '{u: s2_u_q, v: s2_v_q, a: a_full[30:0]};
  assign adv          = !push_valid_o || push_ready_i;
  assign in_i.ready   = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_u_q  <= in_i.u_in;
      s1_v_q  <= in_i.v_in;
      s2_u_q  <= s1_u_q;
      s2_v_q  <= s1_v_q;
      s2_uu_q <= uu_full[30:0];
      s2_vv_q <= vv_full[30:0];
    end
  end

endmodule

`default_nettype wire

[rtl/spfu_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module spfu_queue
  import spfu_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire spfu_item_t push_item_i,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  output spfu_item_t      head_o,
  output logic            head_valid_o,
  input  wire logic       pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  spfu_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/spfu_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module spfu_back
  import spfu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire spfu_item_t head_i,
  input  wire logic       head_valid_i,
  output logic            pop_o,
  spfu_out_if.source      out_o
);

  logic                    en;
  logic                    stg_valid_q [SqrtSteps+1];
  spfu_stage_t             stg_q       [SqrtSteps+1];
  spfu_stage_t             stg_d       [SqrtSteps+1];

  logic                    mul_valid_q;
  logic signed [32:0]      px_q, py_q;
  logic signed [15:0]      mz_q;

  logic                    out_valid_q;
  logic signed [15:0]      x_q, y_q, z_q;

  logic signed [32:0]      zt;
  logic signed [32:0]      px_d, py_d;
  logic [15:0]             root;

  // whole pipeline moves together; the output register frees on a taken beat
  assign en    = !out_valid_q || out_o.ready;
  assign pop_o = en && head_valid_i;

  // z = (2a - 2^30) >>> 15, from the original remainder
  assign zt = $signed({1'b0, head_i.a, 1'b0}) - $signed({1'b0, QOne});

  always_comb begin
    stg_d[0] = '{u: head_i.u, v: head_i.v,
                 z: sat_q15({zt[32], zt[32:15]}),
                 rem: head_i.a, res: '0};
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
    localparam logic [30:0] Bit = 31'(1) << (2 * (SqrtSteps - 1 - j));
    logic [31:0] trial;

    assign trial = {1'b0, stg_q[j].res} + {1'b0, Bit};

    always_comb begin
      stg_d[j+1] = stg_q[j];
      if ({1'b0, stg_q[j].rem} >= trial) begin
        stg_d[j+1].rem = stg_q[j].rem - trial[30:0];
        stg_d[j+1].res = (stg_q[j].res >> 1) + Bit;
      end else begin
        stg_d[j+1].res = stg_q[j].res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= SqrtSteps; i++) begin
        stg_valid_q[i] <= 1'b0;
      end
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      stg_valid_q[0] <= head_valid_i;
      for (int i = 1; i <= SqrtSteps; i++) begin
        stg_valid_q[i] <= stg_valid_q[i-1];
      end
      mul_valid_q <= stg_valid_q[SqrtSteps];
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i <= SqrtSteps; i++) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  // root <= 32768 fits in 16 unsigned bits
  assign root = stg_q[SqrtSteps].res[15:0];
  assign px_d = stg_q[SqrtSteps].u * $signed({1'b0, root});
  assign py_d = stg_q[SqrtSteps].v * $signed({1'b0, root});

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= px_d;
      py_q <= py_d;
      mz_q <= stg_q[SqrtSteps].z;
      x_q  <= sat_q15(px_q[32:14]);
      y_q  <= sat_q15(py_q[32:14]);
      z_q  <= mz_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.x_out = x_q;
  assign out_o.y_out = y_q;
  assign out_o.z_out = z_q;

endmodule

`default_nettype wire
